### hdl/mexp_pkg.sv
package mexp_pkg;
   localparam int ModWidth = 32;
   localparam int CntWidth = $clog2(ModWidth);
   localparam int AddrWidth = 3;

   localparam logic [AddrWidth-1:0] AddrExponent = 3'd0;
   localparam logic [AddrWidth-1:0] AddrModulus  = 3'd4;

   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_MULMOD
   } op_type;

   typedef struct packed {
      logic   load;
      logic   start;
      op_type op;
      logic   use_base;
      logic   set_one;
      logic   set_zero;
   } cmd_type;

   typedef struct packed {
      logic busy;
   } status_type;
endpackage

### hdl/mexp_datapath.sv
module mexp_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  mexp_pkg::cmd_type                cmd,
   output mexp_pkg::status_type             status,
   input  logic [mexp_pkg::ModWidth-1:0]    base_in,
   input  logic [mexp_pkg::ModWidth-1:0]    modulus,
   output logic [mexp_pkg::ModWidth-1:0]    acc_out
);
   localparam int W = mexp_pkg::ModWidth;

   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] base_ff, base_in_nx;
   logic [W-1:0] prod_ff, prod_in;
   logic [W-1:0] mult_ff, mult_in;
   logic [W-1:0] a_ff, a_in;
   logic [mexp_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   mexp_pkg::op_type op_ff, op_in;

   logic [W:0] dbl, dbl_red, add_sum, add_red, rem_sh, rem_sub;
   logic [W-1:0] prod_step;

   always_comb begin
      // shift-and-add modular multiply, MSB first
      dbl       = {prod_ff, 1'b0};
      dbl_red   = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      add_sum   = dbl_red + {1'b0, a_ff};
      add_red   = (add_sum >= {1'b0, modulus}) ? add_sum - {1'b0, modulus} : add_sum;
      prod_step = mult_ff[W-1] ? add_red[W-1:0] : dbl_red[W-1:0];
      // restoring remainder, one bit per cycle
      rem_sh    = {prod_ff, mult_ff[W-1]};
      rem_sub   = (rem_sh >= {1'b0, modulus}) ? rem_sh - {1'b0, modulus} : rem_sh;
   end

   always_comb begin
      acc_in     = acc_ff;
      base_in_nx = base_ff;
      prod_in    = prod_ff;
      mult_in    = mult_ff;
      a_in       = a_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      op_in      = op_ff;
      if (cmd.load) begin
         base_in_nx = base_in;
      end
      if (cmd.set_one) begin
         acc_in = {{(W-1){1'b0}}, 1'b1};
      end
      if (cmd.set_zero) begin
         acc_in = '0;
      end
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         prod_in = '0;
         if (cmd.op == mexp_pkg::OP_REDUCE) begin
            mult_in = base_ff;
         end else begin
            mult_in = cmd.use_base ? base_ff : acc_ff;
         end
         a_in = acc_ff;
      end else if (busy_ff) begin
         if (op_ff == mexp_pkg::OP_REDUCE) begin
            prod_in = rem_sub[W-1:0];
         end else begin
            prod_in = prod_step;
         end
         mult_in = {mult_ff[W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == mexp_pkg::CntWidth'(W-1)) begin
            busy_in = 1'b0;
            if (op_ff == mexp_pkg::OP_REDUCE) begin
               base_in_nx = rem_sub[W-1:0];
            end else begin
               acc_in = prod_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= mexp_pkg::OP_REDUCE;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff  <= acc_in;
      base_ff <= base_in_nx;
      prod_ff <= prod_in;
      mult_ff <= mult_in;
      a_ff    <= a_in;
   end

   assign status.busy = busy_ff;
   assign acc_out     = acc_ff;
endmodule

### hdl/mexp_control.sv
module mexp_control (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [mexp_pkg::ModWidth-1:0] exponent,
   input  logic [mexp_pkg::ModWidth-1:0] modulus,
   input  mexp_pkg::status_type          status,
   output mexp_pkg::cmd_type             cmd,
   output logic                          capture
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_SQUARE,
      S_MULT,
      S_NEXT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [mexp_pkg::CntWidth-1:0] bit_ff, bit_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic launched_ff, launched_in;
   logic req_take;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      launched_in  = launched_ff;
      cmd          = '0;
      capture      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd.load = 1'b1;
               if (exponent == '0) begin
                  cmd.set_one = 1'b1;
                  state_in    = S_DONE;
               end else if (modulus < mexp_pkg::ModWidth'(2)) begin
                  cmd.set_zero = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  cmd.set_one = 1'b1;
                  launched_in = 1'b0;
                  bit_in      = mexp_pkg::CntWidth'(mexp_pkg::ModWidth-1);
                  state_in    = S_REDUCE;
               end
            end
         end
         S_REDUCE, S_SQUARE, S_MULT: begin
            if (!launched_ff) begin
               cmd.start    = 1'b1;
               cmd.op       = (state_ff == S_REDUCE) ? mexp_pkg::OP_REDUCE
                                                     : mexp_pkg::OP_MULMOD;
               cmd.use_base = (state_ff == S_MULT);
               launched_in  = 1'b1;
            end else if (!status.busy) begin
               launched_in = 1'b0;
               if (state_ff == S_SQUARE && exponent[bit_ff]) begin
                  state_in = S_MULT;
               end else if (state_ff == S_REDUCE) begin
                  state_in = S_SQUARE;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            if (bit_ff == '0) begin
               state_in = S_DONE;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = S_SQUARE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               capture      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         launched_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
         launched_ff  <= launched_in;
      end
   end
endmodule

### hdl/modular_exponentiation_core.sv
// When exponent is nonzero and modulus >= 2, the base is first reduced modulo the modulus,
// then each exponent bit costs a modular square, a modular multiply when the bit is set, and
// a step through S_NEXT; each modular product or reduction is a launch, bit-serial steps over
// the 32 modulus bits and a hand-back. The result is set directly when exponent is zero or
// modulus < 2. One request in flight; the next is taken the cycle after the result enters the output register.
// Synchronous active-high reset: exponent 1, modulus 2, no result pending.
module modular_exponentiation_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mexp_pkg::ModWidth-1:0] req_base_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mexp_pkg::ModWidth-1:0] rsp_power_result,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mexp_pkg::AddrWidth-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   logic [31:0] exponent_ff, modulus_ff;
   logic [31:0] result_ff;
   logic wr;
   logic capture;
   mexp_pkg::cmd_type    cmd;
   mexp_pkg::status_type status;
   logic [31:0] acc;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= 32'd1;
         modulus_ff  <= 32'd2;
      end else if (wr) begin
         if (paddr == mexp_pkg::AddrExponent) exponent_ff <= pwdata;
         if (paddr == mexp_pkg::AddrModulus)  modulus_ff  <= pwdata;
      end
   end

   always_comb begin
      case (paddr)
         mexp_pkg::AddrExponent: prdata = exponent_ff;
         mexp_pkg::AddrModulus:  prdata = modulus_ff;
         default:                prdata = '0;
      endcase
   end

   mexp_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .exponent(exponent_ff), .modulus(modulus_ff), .status, .cmd, .capture
   );

   mexp_datapath u_datapath (
      .clock, .reset, .cmd, .status, .base_in(req_base_value),
      .modulus(modulus_ff), .acc_out(acc)
   );

   always_ff @(posedge clock) begin
      if (capture) result_ff <= acc;
   end
   assign rsp_power_result = result_ff;

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> req_stall) else $error("request taken mid-computation");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_power_result))
      else $error("stalled result changed");
   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      capture |-> !(rsp_valid && rsp_stall)) else $error("result overwritten");
endmodule

### bench/modular_exponentiation_core_tb.sv
module modular_exponentiation_core_tb;
   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic [mexp_pkg::ModWidth-1:0]        req_base_value;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [mexp_pkg::ModWidth-1:0]        rsp_power_result;
   logic                                 psel;
   logic                                 penable;
   logic                                 pwrite;
   logic [mexp_pkg::AddrWidth-1:0]       paddr;
   logic [31:0]                          pwdata;
   logic [31:0]                          prdata;
   logic                                 pready;

   logic [mexp_pkg::ModWidth-1:0] key_exponent;
   logic [mexp_pkg::ModWidth-1:0] key_modulus;
   logic [mexp_pkg::ModWidth-1:0] pending_bases[$];
   logic [mexp_pkg::ModWidth-1:0] expected_powers[$];
   int unsigned         error_count;
   int unsigned         checked_count;
   int unsigned         phase_count;
   bit                  no_idle;

   modular_exponentiation_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_base_value(req_base_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_power_result(rsp_power_result),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // square-and-multiply with 64-bit products, one reduction per step
   function automatic logic [mexp_pkg::ModWidth-1:0] mod_power(
         input logic [mexp_pkg::ModWidth-1:0] b);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [mexp_pkg::ModWidth-1:0] e;
      if (key_exponent == '0) return 1;
      if (key_modulus < 2) return 0;
      acc = 1;
      sq  = b % key_modulus;
      e   = key_exponent;
      while (e != '0) begin
         if (e[0]) acc = (acc * sq) % key_modulus;
         sq = (sq * sq) % key_modulus;
         e  = e >> 1;
      end
      return acc[mexp_pkg::ModWidth-1:0];
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [mexp_pkg::ModWidth-1:0] got,
                                  input logic [mexp_pkg::ModWidth-1:0] want);
      $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_powers.push_back(mod_power(req_base_value));
         if (!req_valid || !req_stall) begin
            if (pending_bases.size() > 0 && (no_idle || $urandom_range(99) >= 29)) begin
               req_valid      <= 1'b1;
               req_base_value <= pending_bases.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               report_mismatch("unexpected result", rsp_power_result, '0);
            end else begin
               logic [mexp_pkg::ModWidth-1:0] want;
               want = expected_powers.pop_front();
               if (rsp_power_result !== want)
                  report_mismatch("power_result", rsp_power_result, want);
               checked_count++;
            end
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < 29);
      end
   end

   task automatic csr_write(input logic [mexp_pkg::AddrWidth-1:0] addr,
                            input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == mexp_pkg::AddrExponent) key_exponent = data;
      else key_modulus = data;
   endtask

   task automatic wait_drained();
      while (pending_bases.size() > 0 || req_valid || expected_powers.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_key(input logic [31:0] e, input logic [31:0] n);
      wait_drained();
      csr_write(mexp_pkg::AddrExponent, e);
      csr_write(mexp_pkg::AddrModulus, n);
      phase_count++;
   endtask

   initial begin
      logic [31:0] e;
      logic [31:0] n;
      logic [31:0] b;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_base_value = '0;
      rsp_stall      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      key_exponent   = 1;
      key_modulus    = 2;
      error_count    = 0;
      checked_count  = 0;
      phase_count    = 0;
      no_idle        = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset key: exponent 1, modulus 2
      pending_bases.push_back(0);
      pending_bases.push_back(1);
      pending_bases.push_back('1);
      pending_bases.push_back(32'h8000_0000);
      // zero exponent gives 1 regardless
      set_key(0, '1);
      pending_bases.push_back(0);
      pending_bases.push_back('1);
      // all-ones exponent and modulus
      set_key('1, '1);
      pending_bases.push_back(0);
      pending_bases.push_back(1);
      pending_bases.push_back('1);
      pending_bases.push_back(32'hffff_fffe);
      // modulus one and zero, zero exponent with modulus zero, and modulus two
      set_key(5, 1);
      pending_bases.push_back(7);
      pending_bases.push_back(0);
      set_key(3, 0);
      pending_bases.push_back(9);
      set_key(0, 0);
      pending_bases.push_back(9);
      set_key('1, 2);
      pending_bases.push_back('1);
      // small textbook key, base below, at and above modulus
      set_key(65537, 3233);
      pending_bases.push_back(5000);
      pending_bases.push_back(3233);
      pending_bases.push_back(65);

      for (int p = 0; p < 10; p++) begin
         case ($urandom_range(5))
            0: e = 1;
            1: e = $urandom_range(2, 17);
            2: e = '1;
            default: e = $urandom;
         endcase
         n = ($urandom_range(2) == 0) ? $urandom_range(2, 5000) : $urandom;
         if (n < 2) n = 2;
         no_idle = (p == 4);
         set_key(e, n);
         for (int i = 0; i < 28; i++) begin
            b = ($urandom_range(3) == 0) ? $urandom : ($urandom % n);
            pending_bases.push_back(b);
         end
      end
      no_idle = 1'b0;
      wait_drained();
      repeat (40) @(posedge clock);
      $display("checked %0d results over %0d key settings, incl. zero exponent and modulus 0/1",
               checked_count, phase_count + 1);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(12 * 4000000);
      $display("timeout");
      $display("FAIL");
      $finish;
   end
endmodule
